/* rtl/core/qhf_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, codes and control types of the quaternion heading filter.
package qhf_pkg;

   localparam int QUAT_W = 16;
   localparam int PROD_W = 2 * QUAT_W;
   localparam int ACC_W = PROD_W + 2;
   localparam int MAG_W = ACC_W - 1;

   localparam int NORM_W = 14;
   localparam int SQ_W = 2 * NORM_W;
   localparam int ATAN_K = 19537;
   localparam int K_W = 15;
   localparam int TERM_W = SQ_W + K_W;
   localparam int NUM_W = TERM_W + 1;
   localparam int DEN_W = TERM_W + 2;

   localparam int ANGLE_FRAC_BITS = 6;
   localparam int QUAD_SCALE = 90 << ANGLE_FRAC_BITS;
   localparam int QUO_W = $clog2(QUAD_SCALE + 1);
   localparam int NN_W = NUM_W + QUO_W + 1;

   localparam int HEAD_W = 15;
   localparam logic [HEAD_W-1:0] ANG_90 = HEAD_W'(90 << ANGLE_FRAC_BITS);
   localparam logic [HEAD_W-1:0] ANG_180 = HEAD_W'(180 << ANGLE_FRAC_BITS);
   localparam logic [HEAD_W-1:0] ANG_270 = HEAD_W'(270 << ANGLE_FRAC_BITS);
   localparam logic [HEAD_W-1:0] ANG_359 = HEAD_W'(359 << ANGLE_FRAC_BITS);
   localparam logic [HEAD_W-1:0] ANG_360 = HEAD_W'(360 << ANGLE_FRAC_BITS);

   localparam int BETA_W = 9;
   localparam logic [BETA_W-1:0] BETA_MAX = BETA_W'(256);
   localparam logic [BETA_W-1:0] BETA_RESET = BETA_W'(192);
   localparam int BETA_SHIFT = 8;
   localparam int DIFF_W = HEAD_W + 2;
   localparam int FP_W = DIFF_W + BETA_W + 1;

   localparam int QPROD_N = 6;
   localparam int NPROD_N = 3;
   localparam int CNT_W = $clog2(QUO_W + 1);

   // multiplier operand selects
   localparam int MUL_SEL_W = 4;
   localparam logic [MUL_SEL_W-1:0] MUL_Q1Q2 = 4'd0;
   localparam logic [MUL_SEL_W-1:0] MUL_Q0Q3 = 4'd1;
   localparam logic [MUL_SEL_W-1:0] MUL_Q0Q0 = 4'd2;
   localparam logic [MUL_SEL_W-1:0] MUL_Q1Q1 = 4'd3;
   localparam logic [MUL_SEL_W-1:0] MUL_Q2Q2 = 4'd4;
   localparam logic [MUL_SEL_W-1:0] MUL_Q3Q3 = 4'd5;
   localparam logic [MUL_SEL_W-1:0] MUL_AA = 4'd6;
   localparam logic [MUL_SEL_W-1:0] MUL_AB = 4'd7;
   localparam logic [MUL_SEL_W-1:0] MUL_BB = 4'd8;

   // destinations of the registered product
   localparam int DST_W = 3;
   localparam logic [DST_W-1:0] DST_NONE = 3'd0;
   localparam logic [DST_W-1:0] DST_X_ADD = 3'd1;
   localparam logic [DST_W-1:0] DST_Y_ADD = 3'd2;
   localparam logic [DST_W-1:0] DST_Y_SUB = 3'd3;
   localparam logic [DST_W-1:0] DST_AA = 3'd4;
   localparam logic [DST_W-1:0] DST_AB = 3'd5;
   localparam logic [DST_W-1:0] DST_BB = 3'd6;

   typedef struct packed {
      logic                 load;
      logic [MUL_SEL_W-1:0] mul_sel;
      logic [DST_W-1:0]     dest;
      logic                 prep;
      logic                 norm_shift;
      logic                 kmul;
      logic                 sums;
      logic                 scale;
      logic                 div_step;
      logic                 quad;
      logic                 filt_mul;
      logic                 filt_upd;
      logic                 out_load;
   } qhf_cmd_type;

   typedef struct packed {
      logic special;
      logic norm_done;
   } qhf_stat_type;

endpackage

/* rtl/core/quaternion_heading_filter.sv */
`timescale 1ns / 1ps
// Top level of the quaternion heading filter: sequencer plus datapath.
//
//   channel | signals                                   | direction
//   req     | req_valid/req_ready, imu flag, quat w..z  | in
//   rsp     | rsp_valid/rsp_ready, heading, smoothed    | out
//   csr     | csr_valid/csr_ready, csr_filter_beta      | in
//
// One word at a time. Axis and zero cases skip the normalize shift and the
// restoring divider; others pass through both before rsp_valid. A word with
// the imu flag clear is taken but gives no result. Reset is synchronous;
// beta returns to 192. A stalled rsp holds the next result in the sequencer
// until the slot frees.
module quaternion_heading_filter import qhf_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_imu_ready,
   input  logic signed [QUAT_W-1:0] req_quat_w,
   input  logic signed [QUAT_W-1:0] req_quat_x,
   input  logic signed [QUAT_W-1:0] req_quat_y,
   input  logic signed [QUAT_W-1:0] req_quat_z,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [HEAD_W-1:0]        rsp_heading,
   output logic [HEAD_W-1:0]        rsp_heading_smoothed,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [BETA_W-1:0]        csr_filter_beta
);

   qhf_cmd_type  cmd;
   qhf_stat_type stat;

   assign csr_ready = 1'b1;

   qhf_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_imu_ready (req_imu_ready),
      .req_ready     (req_ready),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .stat          (stat),
      .cmd           (cmd)
   );

   qhf_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .stat                 (stat),
      .req_quat_w           (req_quat_w),
      .req_quat_x           (req_quat_x),
      .req_quat_y           (req_quat_y),
      .req_quat_z           (req_quat_z),
      .csr_we               (csr_valid && csr_ready),
      .csr_filter_beta      (csr_filter_beta),
      .rsp_heading          (rsp_heading),
      .rsp_heading_smoothed (rsp_heading_smoothed)
   );

endmodule

/* rtl/core/qhf_ctrl.sv */
`timescale 1ns / 1ps
// Sequencer of the quaternion heading filter: handshakes and datapath commands.
module qhf_ctrl import qhf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_imu_ready,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   input  qhf_stat_type stat,
   output qhf_cmd_type  cmd
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_MULQ  = 4'd1;
   localparam logic [3:0] S_PREP  = 4'd2;
   localparam logic [3:0] S_NORM  = 4'd3;
   localparam logic [3:0] S_MULN  = 4'd4;
   localparam logic [3:0] S_KMUL  = 4'd5;
   localparam logic [3:0] S_SUMS  = 4'd6;
   localparam logic [3:0] S_SCALE = 4'd7;
   localparam logic [3:0] S_DIV   = 4'd8;
   localparam logic [3:0] S_QUAD  = 4'd9;
   localparam logic [3:0] S_FMUL  = 4'd10;
   localparam logic [3:0] S_FUPD  = 4'd11;
   localparam logic [3:0] S_OUT   = 4'd12;

   logic [3:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      cmd = '0;
      cmd.mul_sel = MUL_Q1Q2;
      cmd.dest = DST_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_imu_ready) begin
               cmd.load = 1'b1;
               cnt_in = '0;
               state_in = S_MULQ;
            end
         end
         S_MULQ: begin
            cmd.mul_sel = MUL_Q1Q2 + MUL_SEL_W'(cnt_ff);
            if (cnt_ff inside {[1:2]}) cmd.dest = DST_X_ADD;
            else if (cnt_ff inside {[3:4]}) cmd.dest = DST_Y_ADD;
            else if (cnt_ff inside {[5:6]}) cmd.dest = DST_Y_SUB;
            if (cnt_ff == CNT_W'(QPROD_N)) state_in = S_PREP;
            else cnt_in = cnt_ff + 1'b1;
         end
         S_PREP: begin
            cmd.prep = 1'b1;
            state_in = stat.special ? S_QUAD : S_NORM;
         end
         S_NORM: begin
            if (stat.norm_done) begin
               cnt_in = '0;
               state_in = S_MULN;
            end else begin
               cmd.norm_shift = 1'b1;
            end
         end
         S_MULN: begin
            cmd.mul_sel = MUL_AA + MUL_SEL_W'(cnt_ff);
            if (cnt_ff == CNT_W'(1)) cmd.dest = DST_AA;
            else if (cnt_ff == CNT_W'(2)) cmd.dest = DST_AB;
            else if (cnt_ff == CNT_W'(3)) cmd.dest = DST_BB;
            if (cnt_ff == CNT_W'(NPROD_N)) state_in = S_KMUL;
            else cnt_in = cnt_ff + 1'b1;
         end
         S_KMUL: begin
            cmd.kmul = 1'b1;
            state_in = S_SUMS;
         end
         S_SUMS: begin
            cmd.sums = 1'b1;
            state_in = S_SCALE;
         end
         S_SCALE: begin
            cmd.scale = 1'b1;
            cnt_in = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == CNT_W'(QUO_W - 1)) state_in = S_QUAD;
            else cnt_in = cnt_ff + 1'b1;
         end
         S_QUAD: begin
            cmd.quad = 1'b1;
            state_in = S_FMUL;
         end
         S_FMUL: begin
            cmd.filt_mul = 1'b1;
            state_in = S_FUPD;
         end
         S_FUPD: begin
            cmd.filt_upd = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (slot_free) begin
               cmd.out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_load_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> slot_free)
      else $error("result word loaded over an untaken one");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_imu_ready) |=> (state_ff == S_MULQ && cnt_ff == '0))
      else $error("accepted word did not start the product sequence");

   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (cnt_ff < CNT_W'(QUO_W)))
      else $error("divider ran past its quotient width");

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.prep, cmd.norm_shift, cmd.kmul, cmd.sums, cmd.scale,
                cmd.div_step, cmd.quad, cmd.filt_mul, cmd.filt_upd, cmd.out_load}))
      else $error("more than one datapath step issued");

   a_busy_until_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FUPD) |=> (state_ff == S_OUT && !req_ready))
      else $error("filter update not followed by result load");
`endif

endmodule

/* rtl/core/qhf_datapath.sv */
`timescale 1ns / 1ps
// Datapath of the quaternion heading filter: products, divider, quadrant map, filter.
module qhf_datapath import qhf_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  qhf_cmd_type              cmd,
   output qhf_stat_type             stat,
   input  logic signed [QUAT_W-1:0] req_quat_w,
   input  logic signed [QUAT_W-1:0] req_quat_x,
   input  logic signed [QUAT_W-1:0] req_quat_y,
   input  logic signed [QUAT_W-1:0] req_quat_z,
   input  logic                     csr_we,
   input  logic [BETA_W-1:0]        csr_filter_beta,
   output logic [HEAD_W-1:0]        rsp_heading,
   output logic [HEAD_W-1:0]        rsp_heading_smoothed
);

   logic signed [QUAT_W-1:0] q0_ff, q0_in, q1_ff, q1_in, q2_ff, q2_in, q3_ff, q3_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_x_ff, acc_x_in, acc_y_ff, acc_y_in;
   logic [MAG_W-1:0]         mag_a_ff, mag_a_in, mag_b_ff, mag_b_in;
   logic [SQ_W-1:0]          aa_ff, aa_in, ab_ff, ab_in, bb_ff, bb_in;
   logic [TERM_W-1:0]        abk_ff, abk_in;
   logic [NUM_W-1:0]         num_ff, num_in;
   logic [DEN_W-1:0]         den_ff, den_in;
   logic [DEN_W-1:0]         rem_ff, rem_in;
   logic [QUO_W-1:0]         nlow_ff, nlow_in, quo_ff, quo_in;
   logic [HEAD_W-1:0]        head_ff, head_in;
   logic signed [FP_W-1:0]   fprod_ff, fprod_in;
   logic [HEAD_W-1:0]        smooth_ff, smooth_in;
   logic [BETA_W-1:0]        beta_ff, beta_in;
   logic [HEAD_W-1:0]        out_head_ff, out_head_in, out_smooth_ff, out_smooth_in;

   logic signed [QUAT_W-1:0] mul_a, mul_b, norm_a, norm_b;
   logic signed [PROD_W-1:0] mul_p;
   logic signed [ACC_W-1:0]  prod_ext, x2, abs_x, abs_y;
   logic [TERM_W-1:0]        aa_sh, bb_sh;
   logic [NN_W-1:0]          nn;
   logic [DEN_W:0]           trial, trial_sub;
   logic                     ge;
   logic                     x_neg, x_zero, y_neg, y_zero;
   logic [HEAD_W-1:0]        fi;
   logic [BETA_W-1:0]        beta_eff;
   logic signed [BETA_W:0]   beta_s;
   logic signed [DIFF_W-1:0] diff;
   logic                     fp_neg;
   logic [FP_W-1:0]          fp_mag, rnd, fstep;

   // shared 16x16 signed multiplier
   assign norm_a = $signed({{(QUAT_W - NORM_W){1'b0}}, mag_a_ff[NORM_W-1:0]});
   assign norm_b = $signed({{(QUAT_W - NORM_W){1'b0}}, mag_b_ff[NORM_W-1:0]});

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.mul_sel)
         MUL_Q1Q2: begin mul_a = q1_ff;  mul_b = q2_ff;  end
         MUL_Q0Q3: begin mul_a = q0_ff;  mul_b = q3_ff;  end
         MUL_Q0Q0: begin mul_a = q0_ff;  mul_b = q0_ff;  end
         MUL_Q1Q1: begin mul_a = q1_ff;  mul_b = q1_ff;  end
         MUL_Q2Q2: begin mul_a = q2_ff;  mul_b = q2_ff;  end
         MUL_Q3Q3: begin mul_a = q3_ff;  mul_b = q3_ff;  end
         MUL_AA:   begin mul_a = norm_a; mul_b = norm_a; end
         MUL_AB:   begin mul_a = norm_a; mul_b = norm_b; end
         MUL_BB:   begin mul_a = norm_b; mul_b = norm_b; end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;
   assign prod_ext = {{(ACC_W - PROD_W){prod_ff[PROD_W-1]}}, prod_ff};

   assign x2 = {acc_x_ff[ACC_W-2:0], 1'b0};
   assign abs_x = x2[ACC_W-1] ? -x2 : x2;
   assign abs_y = acc_y_ff[ACC_W-1] ? -acc_y_ff : acc_y_ff;

   assign x_neg = acc_x_ff[ACC_W-1];
   assign x_zero = (acc_x_ff == '0);
   assign y_neg = acc_y_ff[ACC_W-1];
   assign y_zero = (acc_y_ff == '0);

   assign stat.special = x_zero || y_zero;
   assign stat.norm_done = ((mag_a_ff | mag_b_ff) >> NORM_W) == '0;

   assign aa_sh = {aa_ff, {K_W{1'b0}}};
   assign bb_sh = {bb_ff, {K_W{1'b0}}};
   assign nn = NN_W'(num_ff) * NN_W'(QUAD_SCALE) + NN_W'(den_ff >> 1);

   // restoring divide, one quotient bit a step
   assign trial = {rem_ff, nlow_ff[QUO_W-1]};
   assign ge = (trial >= {1'b0, den_ff});
   assign trial_sub = trial - {1'b0, den_ff};

   assign fi = (den_ff == '0) ? '0 : HEAD_W'(quo_ff);

   assign beta_eff = (beta_ff > BETA_MAX) ? BETA_MAX : beta_ff;
   assign beta_s = $signed({1'b0, beta_eff});
   assign diff = $signed({2'b00, head_ff}) - $signed({2'b00, smooth_ff});
   assign fp_neg = fprod_ff[FP_W-1];
   assign fp_mag = fp_neg ? FP_W'(-fprod_ff) : FP_W'(fprod_ff);
   assign rnd = (fp_mag + FP_W'(1 << (BETA_SHIFT - 1))) >> BETA_SHIFT;
   assign fstep = fp_neg ? -rnd : rnd;

   always_comb begin
      q0_in = q0_ff;
      q1_in = q1_ff;
      q2_in = q2_ff;
      q3_in = q3_ff;
      prod_in = mul_p;
      acc_x_in = acc_x_ff;
      acc_y_in = acc_y_ff;
      mag_a_in = mag_a_ff;
      mag_b_in = mag_b_ff;
      aa_in = aa_ff;
      ab_in = ab_ff;
      bb_in = bb_ff;
      abk_in = abk_ff;
      num_in = num_ff;
      den_in = den_ff;
      rem_in = rem_ff;
      nlow_in = nlow_ff;
      quo_in = quo_ff;
      head_in = head_ff;
      fprod_in = fprod_ff;
      smooth_in = smooth_ff;
      beta_in = beta_ff;
      out_head_in = out_head_ff;
      out_smooth_in = out_smooth_ff;

      if (cmd.load) begin
         q0_in = req_quat_w;
         q1_in = req_quat_x;
         q2_in = req_quat_y;
         q3_in = req_quat_z;
         acc_x_in = '0;
         acc_y_in = '0;
      end

      case (cmd.dest)
         DST_NONE:  ;
         DST_X_ADD: acc_x_in = acc_x_ff + prod_ext;
         DST_Y_ADD: acc_y_in = acc_y_ff + prod_ext;
         DST_Y_SUB: acc_y_in = acc_y_ff - prod_ext;
         DST_AA:    aa_in = prod_ff[SQ_W-1:0];
         DST_AB:    ab_in = prod_ff[SQ_W-1:0];
         DST_BB:    bb_in = prod_ff[SQ_W-1:0];
         default:   ;
      endcase

      if (cmd.prep) begin
         mag_a_in = abs_x[MAG_W-1:0];
         mag_b_in = abs_y[MAG_W-1:0];
      end
      if (cmd.norm_shift) begin
         mag_a_in = mag_a_ff >> 1;
         mag_b_in = mag_b_ff >> 1;
      end
      if (cmd.kmul) abk_in = TERM_W'(ab_ff) * TERM_W'(ATAN_K);
      if (cmd.sums) begin
         num_in = NUM_W'(abk_ff) + NUM_W'(aa_sh);
         den_in = DEN_W'(bb_sh) + DEN_W'({abk_ff, 1'b0}) + DEN_W'(aa_sh);
      end
      if (cmd.scale) begin
         rem_in = nn[NN_W-1:QUO_W];
         nlow_in = nn[QUO_W-1:0];
         quo_in = '0;
      end
      if (cmd.div_step) begin
         rem_in = ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
         nlow_in = nlow_ff << 1;
         quo_in = {quo_ff[QUO_W-2:0], ge};
      end

      if (cmd.quad) begin
         if (x_neg && y_zero) head_in = ANG_270;
         else if (!x_zero && y_zero) head_in = ANG_90;
         else if (x_zero && y_zero) head_in = ANG_359;
         else if (x_zero && !y_neg) head_in = '0;
         else if (x_zero) head_in = ANG_180;
         else if (!x_neg && !y_neg) head_in = fi;
         else if (x_neg && !y_neg) head_in = ANG_360 - fi;
         else if (!x_neg) head_in = ANG_180 - fi;
         else head_in = fi + ANG_180;
      end

      if (cmd.filt_mul) fprod_in = beta_s * diff;
      if (cmd.filt_upd) smooth_in = smooth_ff + fstep[HEAD_W-1:0];

      if (cmd.out_load) begin
         out_head_in = head_ff;
         out_smooth_in = smooth_ff;
      end

      if (csr_we) beta_in = csr_filter_beta;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beta_ff <= BETA_RESET;
         smooth_ff <= '0;
      end else begin
         beta_ff <= beta_in;
         smooth_ff <= smooth_in;
      end
   end

   always_ff @(posedge clock) begin
      q0_ff <= q0_in;
      q1_ff <= q1_in;
      q2_ff <= q2_in;
      q3_ff <= q3_in;
      prod_ff <= prod_in;
      acc_x_ff <= acc_x_in;
      acc_y_ff <= acc_y_in;
      mag_a_ff <= mag_a_in;
      mag_b_ff <= mag_b_in;
      aa_ff <= aa_in;
      ab_ff <= ab_in;
      bb_ff <= bb_in;
      abk_ff <= abk_in;
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      nlow_ff <= nlow_in;
      quo_ff <= quo_in;
      head_ff <= head_in;
      fprod_ff <= fprod_in;
      out_head_ff <= out_head_in;
      out_smooth_ff <= out_smooth_in;
   end

   assign rsp_heading = out_head_ff;
   assign rsp_heading_smoothed = out_smooth_ff;

endmodule
